FILE: design/rcg_pkg.sv
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared widths, register codes and pipeline sideband types of the
// pinhole camera ray generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcg_pkg;

  // field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned AXIS_W     = 18;   // Q4.14 basis component
  localparam int unsigned POS_W      = 20;   // Q12.8 position component
  localparam int unsigned DIR_W      = 16;   // Q1.15 direction component
  localparam int unsigned NUM_LANES  = 3;

  // datapath widths
  localparam int unsigned SCALE_W    = AXIS_W;         // 2u-1 as signed Q1.16
  localparam int unsigned PROD_W     = 2 * AXIS_W;     // raw direction sum
  localparam int unsigned MAG_W      = PROD_W - 1;     // |raw direction|
  localparam int unsigned A_W        = 31;             // magnitude after scaling down
  localparam int unsigned SQ_W       = 2 * A_W;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned Q_W        = DIR_W;
  localparam int unsigned NUM_W      = A_W + Q_W + 1;  // (a << 16) + len
  localparam int unsigned SHIFT_W    = 3;

  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned DIV_STEPS   = Q_W;

  // squared length at or below which the direction is too short to scale
  localparam logic [SUM_W-1:0] DEGEN_SQ_LIMIT = 64'd1152921;

  localparam logic [Q_W-1:0] Q_POS_MAX = 16'd32767;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 16'd32768;

  // configuration port
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_ADDR_W   = 5;
  localparam int unsigned CFG_ADDR_LSB = 3;
  localparam int unsigned BASIS_W      = NUM_LANES * AXIS_W;
  localparam int unsigned EYE_W        = NUM_LANES * POS_W;

  typedef enum logic [1:0] {
    REG_BASIS_X = 2'd0,
    REG_BASIS_Y = 2'd1,
    REG_BASIS_Z = 2'd2,
    REG_EYE_POS = 2'd3
  } reg_idx_t;

  // sideband travelling alongside the square root
  typedef struct packed {
    logic [NUM_LANES-1:0][A_W-1:0] mag;
    logic [NUM_LANES-1:0]          neg;
    logic                          degen;
  } sqrt_side_t;

  // sideband travelling alongside the dividers
  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic                 degen;
    logic                 zero_out;
  } div_side_t;

endpackage

FILE: design/rcg_chan_if.sv
// ----------------------------------------------------------------------------
// rcg channel interfaces
// Valid/ready channels for image-plane samples and for generated rays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rcg_sample_if;
  logic                             valid;
  logic                             ready;
  logic [rcg_pkg::SAMPLE_W-1:0]     sample_u;
  logic [rcg_pkg::SAMPLE_W-1:0]     sample_v;

  modport source (output valid, output sample_u, output sample_v, input ready);
  modport sink   (input valid, input sample_u, input sample_v, output ready);
endinterface

interface rcg_ray_if;
  logic                             valid;
  logic                             ready;
  logic signed [rcg_pkg::POS_W-1:0] origin_x;
  logic signed [rcg_pkg::POS_W-1:0] origin_y;
  logic signed [rcg_pkg::POS_W-1:0] origin_z;
  logic signed [rcg_pkg::DIR_W-1:0] dir_x;
  logic signed [rcg_pkg::DIR_W-1:0] dir_y;
  logic signed [rcg_pkg::DIR_W-1:0] dir_z;
  logic                             degenerate;

  modport source (output valid, output origin_x, output origin_y, output origin_z,
                  output dir_x, output dir_y, output dir_z, output degenerate,
                  input ready);
  modport sink   (input valid, input origin_x, input origin_y, input origin_z,
                  input dir_x, input dir_y, input dir_z, input degenerate,
                  output ready);
endinterface

FILE: design/rcg_isqrt.sv
// ----------------------------------------------------------------------------
// rcg_isqrt
// Pipelined 64-bit integer square root, one result bit per stage, with a
// sideband that travels in step with the operand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcg_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rcg_pkg::SUM_W-1:0]   in_n,
  input  rcg_pkg::sqrt_side_t         in_side,
  output logic                        out_valid,
  output logic [rcg_pkg::ROOT_W-1:0]  out_root,
  output rcg_pkg::sqrt_side_t         out_side
);

  localparam int unsigned ST = rcg_pkg::SQRT_STAGES;
  localparam int unsigned SW = rcg_pkg::SUM_W;

  logic [ST-1:0]       valid_r;
  logic [SW-1:0]       n_r    [ST];
  logic [SW-1:0]       res_r  [ST];
  rcg_pkg::sqrt_side_t side_r [ST];

  for (genvar gi = 0; gi < ST; gi++) begin : g_step
    localparam int unsigned BitPos = SW - 2 - 2 * gi;

    logic [SW-1:0]       n_in;
    logic [SW-1:0]       res_in;
    logic [SW-1:0]       bit_c;
    logic [SW-1:0]       trial;
    logic                v_in;
    logic                take;
    rcg_pkg::sqrt_side_t side_in;

    if (gi == 0) begin : g_first
      assign n_in    = in_n;
      assign res_in  = '0;
      assign v_in    = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign n_in    = n_r[gi-1];
      assign res_in  = res_r[gi-1];
      assign v_in    = valid_r[gi-1];
      assign side_in = side_r[gi-1];
    end

    assign bit_c = SW'(1) << BitPos;
    // partial root and trial bit never overlap
    assign trial = res_in | bit_c;
    assign take  = (n_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[gi] <= 1'b0;
      end else if (en) begin
        valid_r[gi] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[gi]    <= take ? (n_in - trial) : n_in;
        res_r[gi]  <= take ? ((res_in >> 1) | bit_c) : (res_in >> 1);
        side_r[gi] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[ST-1];
  assign out_root  = res_r[ST-1][rcg_pkg::ROOT_W-1:0];
  assign out_side  = side_r[ST-1];

endmodule

FILE: design/rcg_div.sv
// ----------------------------------------------------------------------------
// rcg_div
// Three-lane pipelined restoring divider: q = ((a << 16) + len) / (2 * len),
// one quotient bit per stage after the load stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcg_div (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  logic                                                   in_valid,
  input  logic [rcg_pkg::ROOT_W-1:0]                             in_root,
  input  logic [rcg_pkg::NUM_LANES-1:0][rcg_pkg::A_W-1:0]        in_mag,
  input  rcg_pkg::div_side_t                                     in_side,
  output logic                                                   out_valid,
  output logic [rcg_pkg::NUM_LANES-1:0][rcg_pkg::Q_W-1:0]        out_q,
  output rcg_pkg::div_side_t                                     out_side
);

  localparam int unsigned ST = rcg_pkg::DIV_STEPS + 1;
  localparam int unsigned NL = rcg_pkg::NUM_LANES;
  localparam int unsigned NW = rcg_pkg::NUM_W;
  localparam int unsigned QW = rcg_pkg::Q_W;
  localparam int unsigned DW = rcg_pkg::ROOT_W + 1;

  logic [ST-1:0]                valid_r;
  logic [NL-1:0][NW-1:0]        rem_r  [ST];
  logic [NL-1:0][QW-1:0]        q_r    [ST];
  logic [DW-1:0]                dv_r   [ST];
  rcg_pkg::div_side_t           side_r [ST];

  for (genvar gs = 0; gs < ST; gs++) begin : g_stage
    logic [NL-1:0][NW-1:0] rem_nxt;
    logic [NL-1:0][QW-1:0] q_nxt;
    logic [DW-1:0]         dv_nxt;
    logic                  v_in;
    rcg_pkg::div_side_t    side_in;

    if (gs == 0) begin : g_load
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign dv_nxt  = {in_root, 1'b0};
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          rem_nxt[l] = NW'({in_mag[l], {QW{1'b0}}}) + NW'(in_root);
          q_nxt[l]   = '0;
        end
      end
    end else begin : g_step
      localparam int unsigned J = ST - 1 - gs;
      logic [NW:0] dv_sh;

      assign v_in    = valid_r[gs-1];
      assign side_in = side_r[gs-1];
      assign dv_nxt  = dv_r[gs-1];
      assign dv_sh   = (NW + 1)'(dv_r[gs-1]) << J;

      always_comb begin
        for (int l = 0; l < NL; l++) begin
          if ({1'b0, rem_r[gs-1][l]} >= dv_sh) begin
            rem_nxt[l] = rem_r[gs-1][l] - dv_sh[NW-1:0];
            q_nxt[l]   = {q_r[gs-1][l][QW-2:0], 1'b1};
          end else begin
            rem_nxt[l] = rem_r[gs-1][l];
            q_nxt[l]   = {q_r[gs-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[gs] <= 1'b0;
      end else if (en) begin
        valid_r[gs] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gs]  <= rem_nxt;
        q_r[gs]    <= q_nxt;
        dv_r[gs]   <= dv_nxt;
        side_r[gs] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[ST-1];
  assign out_q     = q_r[ST-1];
  assign out_side  = side_r[ST-1];

endmodule

FILE: design/pinhole_camera_ray_generator.sv
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator
// Throughput: one sample per cycle while the skid entry is empty; the square
// root (32 stages) and the dividers (17 stages) are fully pipelined and a
// two-entry output stage keeps input ready while only one finished ray waits.
// Reset: synchronous active-low rst_n empties the pipeline and clears the
// camera registers to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pinhole_camera_ray_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rcg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rcg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  rcg_sample_if.sink                        in_chan,
  rcg_ray_if.source                         out_chan
);

  localparam int unsigned NL  = rcg_pkg::NUM_LANES;
  localparam int unsigned AW  = rcg_pkg::AXIS_W;
  localparam int unsigned PW  = rcg_pkg::PROD_W;
  localparam int unsigned MW  = rcg_pkg::MAG_W;
  localparam int unsigned A_W = rcg_pkg::A_W;
  localparam int unsigned SQW = rcg_pkg::SQ_W;
  localparam int unsigned SMW = rcg_pkg::SUM_W;
  localparam int unsigned QW  = rcg_pkg::Q_W;
  localparam int unsigned SCW = rcg_pkg::SCALE_W;
  localparam int unsigned FRONT_STAGES = 7;

  typedef struct packed {
    logic [NL-1:0][QW-1:0] dir;
    logic                  degenerate;
  } ray_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [rcg_pkg::BASIS_W-1:0] basis_x_r, basis_y_r, basis_z_r;
  logic [rcg_pkg::EYE_W-1:0]   eye_pos_r;
  logic                        cfg_wr;
  rcg_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = rcg_pkg::reg_idx_t'(paddr[rcg_pkg::CFG_ADDR_W-1:rcg_pkg::CFG_ADDR_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_x_r <= '0;
      basis_y_r <= '0;
      basis_z_r <= '0;
      eye_pos_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rcg_pkg::REG_BASIS_X: basis_x_r <= pwdata[rcg_pkg::BASIS_W-1:0];
        rcg_pkg::REG_BASIS_Y: basis_y_r <= pwdata[rcg_pkg::BASIS_W-1:0];
        rcg_pkg::REG_BASIS_Z: basis_z_r <= pwdata[rcg_pkg::BASIS_W-1:0];
        rcg_pkg::REG_EYE_POS: eye_pos_r <= pwdata[rcg_pkg::EYE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rcg_pkg::REG_BASIS_X: prdata = rcg_pkg::CFG_DATA_W'(basis_x_r);
      rcg_pkg::REG_BASIS_Y: prdata = rcg_pkg::CFG_DATA_W'(basis_y_r);
      rcg_pkg::REG_BASIS_Z: prdata = rcg_pkg::CFG_DATA_W'(basis_z_r);
      rcg_pkg::REG_EYE_POS: prdata = rcg_pkg::CFG_DATA_W'(eye_pos_r);
      default:              prdata = '0;
    endcase
  end

  logic signed [AW-1:0] bx [NL];
  logic signed [AW-1:0] by [NL];
  logic signed [AW-1:0] bz [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      bx[l] = $signed(basis_x_r[l*AW +: AW]);
      by[l] = $signed(basis_y_r[l*AW +: AW]);
      bz[l] = $signed(basis_z_r[l*AW +: AW]);
    end
  end

  // --------------------------------------------------------------------------
  // front stages: scale, products, sum, magnitude, shift, squares, length^2
  // --------------------------------------------------------------------------
  logic                          en;
  logic [FRONT_STAGES-1:0]       fv_r;

  logic signed [SCW-1:0]         su_r, sv_r;
  logic signed [PW-1:0]          px_r [NL];
  logic signed [PW-1:0]          py_r [NL];
  logic signed [PW-1:0]          d_r  [NL];
  logic [NL-1:0][MW-1:0]         mag_r;
  logic [NL-1:0]                 neg3_r, neg4_r, neg5_r, neg6_r;
  logic [NL-1:0][A_W-1:0]        a4_r, a5_r, a6_r;
  logic                          k0_4_r, k0_5_r;
  logic [SQW-1:0]                sq_r [NL];
  logic [SMW-1:0]                len_sq_r;
  logic                          degen6_r;

  logic signed [SCW-1:0]         su_nxt, sv_nxt;
  logic signed [PW-1:0]          d_nxt [NL];
  logic [NL-1:0][MW-1:0]         mag_nxt;
  logic [NL-1:0]                 neg_nxt;
  logic [MW-1:0]                 mag_or;
  logic [rcg_pkg::SHIFT_W-1:0]   k;
  logic [NL-1:0][A_W-1:0]        a_nxt;
  logic [SMW-1:0]                len_sq_nxt;

  assign su_nxt = $signed({1'b0, in_chan.sample_u, 1'b0}) - $signed(SCW'(1) << (SCW - 2));
  assign sv_nxt = $signed({1'b0, in_chan.sample_v, 1'b0}) - $signed(SCW'(1) << (SCW - 2));

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      d_nxt[l] = px_r[l] + py_r[l] + PW'($signed({bz[l], {QW{1'b0}}}));
    end
  end

  always_comb begin
    logic [PW-1:0] neg_d;
    for (int l = 0; l < NL; l++) begin
      neg_d      = -d_r[l];
      neg_nxt[l] = d_r[l][PW-1];
      mag_nxt[l] = neg_nxt[l] ? neg_d[MW-1:0] : d_r[l][MW-1:0];
    end
  end

  // smallest shift that brings the largest magnitude below 2^31
  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];
  always_comb begin
    if (mag_or[MW-1])      k = 3'd4;
    else if (mag_or[MW-2]) k = 3'd3;
    else if (mag_or[MW-3]) k = 3'd2;
    else if (mag_or[MW-4]) k = 3'd1;
    else                   k = 3'd0;
  end

  always_comb begin
    logic [MW-1:0] sh;
    for (int l = 0; l < NL; l++) begin
      sh       = mag_r[l] >> k;
      a_nxt[l] = sh[A_W-1:0];
    end
  end

  assign len_sq_nxt = SMW'(sq_r[0]) + SMW'(sq_r[1]) + SMW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[FRONT_STAGES-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_r <= su_nxt;
      sv_r <= sv_nxt;
      for (int l = 0; l < NL; l++) begin
        px_r[l] <= bx[l] * su_r;
        py_r[l] <= by[l] * sv_r;
        d_r[l]  <= d_nxt[l];
        sq_r[l] <= SQW'(a4_r[l]) * SQW'(a4_r[l]);
      end
      mag_r    <= mag_nxt;
      neg3_r   <= neg_nxt;
      a4_r     <= a_nxt;
      neg4_r   <= neg3_r;
      k0_4_r   <= (k == '0);
      a5_r     <= a4_r;
      neg5_r   <= neg4_r;
      k0_5_r   <= k0_4_r;
      len_sq_r <= len_sq_nxt;
      a6_r     <= a5_r;
      neg6_r   <= neg5_r;
      degen6_r <= k0_5_r && (len_sq_nxt <= rcg_pkg::DEGEN_SQ_LIMIT);
    end
  end

  // --------------------------------------------------------------------------
  // length and division
  // --------------------------------------------------------------------------
  rcg_pkg::sqrt_side_t             sq_side_in, sq_side_out;
  logic                            sq_valid;
  logic [rcg_pkg::ROOT_W-1:0]      root;
  rcg_pkg::div_side_t              dv_side_in, dv_side_out;
  logic                            dv_valid;
  logic [NL-1:0][QW-1:0]           quo;

  assign sq_side_in.mag   = a6_r;
  assign sq_side_in.neg   = neg6_r;
  assign sq_side_in.degen = degen6_r;

  rcg_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fv_r[FRONT_STAGES-1]),
    .in_n     (len_sq_r),
    .in_side  (sq_side_in),
    .out_valid(sq_valid),
    .out_root (root),
    .out_side (sq_side_out)
  );

  assign dv_side_in.neg      = sq_side_out.neg;
  assign dv_side_in.degen    = sq_side_out.degen;
  assign dv_side_in.zero_out = sq_side_out.degen || (root == '0);

  rcg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_valid),
    .in_root  (root),
    .in_mag   (sq_side_out.mag),
    .in_side  (dv_side_in),
    .out_valid(dv_valid),
    .out_q    (quo),
    .out_side (dv_side_out)
  );

  // sign and saturation
  ray_t ray_nxt;
  always_comb begin
    logic [QW-1:0] qs;
    for (int l = 0; l < NL; l++) begin
      if (dv_side_out.zero_out) begin
        qs = '0;
      end else if (!dv_side_out.neg[l]) begin
        qs = (quo[l] > rcg_pkg::Q_POS_MAX) ? rcg_pkg::Q_POS_MAX : quo[l];
      end else begin
        qs = (quo[l] > rcg_pkg::Q_NEG_MAX) ? rcg_pkg::Q_NEG_MAX : quo[l];
      end
      ray_nxt.dir[l] = dv_side_out.neg[l] ? (-qs) : qs;
    end
    ray_nxt.degenerate = dv_side_out.degen;
  end

  // --------------------------------------------------------------------------
  // output register with skid entry
  // --------------------------------------------------------------------------
  logic out_valid_r, skid_valid_r;
  ray_t out_r, skid_r;

  assign en = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (en) begin
      if (out_valid_r && !out_chan.ready) begin
        skid_valid_r <= dv_valid;
      end else begin
        out_valid_r <= dv_valid;
      end
    end else if (out_chan.ready) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_valid_r && !out_chan.ready) begin
        skid_r <= ray_nxt;
      end else begin
        out_r <= ray_nxt;
      end
    end else if (out_chan.ready) begin
      out_r <= skid_r;
    end
  end

  assign in_chan.ready       = en;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.dir_x      = $signed(out_r.dir[0]);
  assign out_chan.dir_y      = $signed(out_r.dir[1]);
  assign out_chan.dir_z      = $signed(out_r.dir[2]);
  assign out_chan.degenerate = out_r.degenerate;
  // the user must change position only while no item is in flight; not enforced here
  assign out_chan.origin_x   = $signed(eye_pos_r[0*rcg_pkg::POS_W +: rcg_pkg::POS_W]);
  assign out_chan.origin_y   = $signed(eye_pos_r[1*rcg_pkg::POS_W +: rcg_pkg::POS_W]);
  assign out_chan.origin_z   = $signed(eye_pos_r[2*rcg_pkg::POS_W +: rcg_pkg::POS_W]);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while output register is empty");

  a_degen_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.degenerate) |->
      (out_chan.dir_x == '0 && out_chan.dir_y == '0 && out_chan.dir_z == '0))
    else $error("degenerate ray carries a nonzero direction");

  a_ready_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_chan.ready) |-> $past(out_chan.valid && !out_chan.ready))
    else $error("input ready dropped without a stalled output");

endmodule
